@@ sv/tcp_connection_tracker_defines.svh @@
// Assertion macros shared by the connection tracker RTL.
// No dependencies; included by the modules that carry checks.
`ifndef TCP_CONNECTION_TRACKER_DEFINES_SVH
`define TCP_CONNECTION_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge, ignored while reset is asserted.
`define TCP_CT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcp connection tracker check failed");
// Check a property on every clock edge, reset included.
`define TCP_CT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tcp connection tracker check failed");
`else
`define TCP_CT_ASSERT(lbl, clk, rst_n, prop)
`define TCP_CT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ sv/tcp_ct_pkg.sv @@
// Types and codes for the TCP connection tracker.
// No dependencies; imported by all tracker modules.
package tcp_ct_pkg;

    localparam int LIMIT_W = 5;
    localparam int TUPLE_W = 96;
    localparam int ENTRY_W = TUPLE_W + 2;

    // Connection states
    localparam logic [1:0] ST_CLOSED       = 2'd0;
    localparam logic [1:0] ST_LISTEN       = 2'd1;
    localparam logic [1:0] ST_SYN_RECEIVED = 2'd2;
    localparam logic [1:0] ST_ESTABLISHED  = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_MATCHED = 2'd0;
    localparam logic [1:0] STATUS_CREATED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    // Action codes
    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_SYN_ACK   = 2'd1;
    localparam logic [1:0] ACT_SEND_DATA = 2'd2;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
    } t_tuple;

    // Head of the segment queue as seen by the lookup engine
    typedef struct packed {
        logic   valid;
        t_tuple tuple;
    } t_q_head;

endpackage

@@ sv/tcp_ct_ifs.sv @@
// Valid/ready channel interfaces for segments in and lookup results out.
// No dependencies.
interface tcp_ct_seg_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_ip;
    logic [15:0] source_port;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;

    modport source (output valid, source_ip, source_port, dest_ip, dest_port,
                    input ready);
    modport sink (input valid, source_ip, source_port, dest_ip, dest_port,
                  output ready);
endinterface

interface tcp_ct_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] slot;
    logic [1:0] status;
    logic [1:0] action;
    logic [1:0] conn_state;

    modport source (output valid, slot, status, action, conn_state, input ready);
    modport sink (input valid, slot, status, action, conn_state, output ready);
endinterface

@@ sv/tcp_ct_queue.sv @@
// Front end: accepts segment beats and holds their four-tuples in a
// two-deep queue. Depends on tcp_ct_pkg and tcp_ct_seg_if.
`include "tcp_connection_tracker_defines.svh"

module tcp_ct_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tcp_ct_seg_if.sink         i_seg,
    output tcp_ct_pkg::t_q_head o_head,
    input  logic               i_pop
);
    import tcp_ct_pkg::*;

    t_tuple     r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       push;
    logic       pop;

    // Accept while a slot is free
    assign i_seg.ready = (r_count != 2'd2);
    assign push = i_seg.valid && i_seg.ready;
    assign pop  = i_pop && (r_count != 2'd0);

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.tuple = r_slot[r_rd_ptr];

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // Capture the tuple of an accepted beat
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= '{src_addr: i_seg.source_ip, src_port: i_seg.source_port,
                                  dst_addr: i_seg.dest_ip, dst_port: i_seg.dest_port};
        end
    end

    `TCP_CT_ASSERT(a_queue_bound, i_clk, i_rst_n, r_count != 2'd3)
    `TCP_CT_ASSERT(a_queue_ptrs, i_clk, i_rst_n, (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))

endmodule

@@ sv/tcp_ct_engine.sv @@
// Back end: scans the connection table one entry per cycle, then updates
// or appends the entry unless the table is full, and registers the result. Depends on tcp_ct_pkg.
`include "tcp_connection_tracker_defines.svh"

module tcp_ct_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcp_ct_pkg::t_q_head           i_head,
    output logic                          o_pop,
    input  logic [tcp_ct_pkg::LIMIT_W-1:0] i_limit,
    tcp_ct_res_if.source                  o_res
);
    import tcp_ct_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    // Connection table: four-tuple and state per entry
    logic [ENTRY_W-1:0] mem [CAPACITY];
    logic [ENTRY_W-1:0] r_rd_data;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_filled;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_found;
    logic             n_found;
    t_tuple           r_tuple;

    logic             r_out_valid;
    logic [3:0]       r_slot;
    logic [1:0]       r_status;
    logic [1:0]       r_action;
    logic [1:0]       r_conn_state;

    logic [CNT_W-1:0] idx_next;
    logic             entry_match;
    logic             last_entry;
    logic             full;
    logic             out_free;
    logic             take;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             finish;
    logic             do_write;
    logic             do_create;
    logic [IDX_W-1:0] slot_idx;
    logic [1:0]       cur_st;
    logic [1:0]       new_st;
    logic [1:0]       new_act;

    assign idx_next    = CNT_W'(r_idx) + CNT_W'(1);
    assign entry_match = (r_rd_data[ENTRY_W-1:2] == r_tuple);
    assign last_entry  = (idx_next >= r_filled);
    assign full        = (CMP_W'(r_filled) >= CMP_W'(i_limit)) ||
                         (r_filled >= CNT_W'(CAPACITY));
    assign out_free    = !r_out_valid || o_res.ready;

    assign o_pop   = (r_state == S_IDLE);
    assign take    = (r_state == S_IDLE) && i_head.valid;
    assign finish  = (r_state == S_UPDATE) && out_free;

    // Read the next entry only while the scan goes on
    assign rd_en   = take || ((r_state == S_SEARCH) && !entry_match && !last_entry);
    assign rd_addr = (r_state == S_IDLE) ? '0 : IDX_W'(idx_next);

    // Advance the handshake state of the selected entry
    always_comb begin
        cur_st  = r_found ? r_rd_data[1:0] : ST_LISTEN;
        new_st  = cur_st;
        new_act = ACT_NONE;
        unique case (cur_st)
            ST_LISTEN: begin
                new_st  = ST_SYN_RECEIVED;
                new_act = ACT_SYN_ACK;
            end
            ST_SYN_RECEIVED: begin
                new_st  = ST_ESTABLISHED;
                new_act = ACT_SEND_DATA;
            end
            default: begin
                new_st  = cur_st;
                new_act = ACT_NONE;
            end
        endcase
    end

    assign slot_idx  = r_found ? r_idx : IDX_W'(r_filled);
    assign do_create = finish && !r_found && !full;
    assign do_write  = finish && (r_found || !full);

    // Sequence: take a tuple, scan, update
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_found = r_found;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = (r_filled == '0) ? S_UPDATE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                priority if (entry_match) begin
                    n_found = 1'b1;
                    n_state = S_UPDATE;
                end else if (last_entry) begin
                    n_state = S_UPDATE;
                end else begin
                    n_idx = IDX_W'(idx_next);
                end
            end
            S_UPDATE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filled    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_create) begin
                r_filled <= r_filled + CNT_W'(1);
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scan index, match flag and the tuple under search
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_found <= n_found;
        if (take) begin
            r_tuple <= i_head.tuple;
        end
    end

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem[slot_idx] <= {r_tuple, new_st};
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Result register; hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (finish) begin
            if (!r_found && full) begin
                r_slot       <= 4'd0;
                r_status     <= STATUS_FULL;
                r_action     <= ACT_NONE;
                r_conn_state <= ST_CLOSED;
            end else begin
                r_slot       <= 4'(slot_idx);
                r_status     <= r_found ? STATUS_MATCHED : STATUS_CREATED;
                r_action     <= new_act;
                r_conn_state <= new_st;
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.slot       = r_slot;
    assign o_res.status     = r_status;
    assign o_res.action     = r_action;
    assign o_res.conn_state = r_conn_state;

    `TCP_CT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (r_filled == '0))
    `TCP_CT_ASSERT(a_fill_bound, i_clk, i_rst_n, r_filled <= CNT_W'(CAPACITY))
    `TCP_CT_ASSERT(a_scan_in_range, i_clk, i_rst_n, (r_state == S_SEARCH) |-> (CNT_W'(r_idx) < r_filled))
    `TCP_CT_ASSERT(a_create_count, i_clk, i_rst_n, do_create |=> (r_filled == $past(r_filled) + CNT_W'(1)))

endmodule

@@ sv/tcp_connection_tracker.sv @@
// Top level of the TCP connection tracker: limit register, segment queue
// and lookup engine. Depends on tcp_ct_pkg, tcp_ct_ifs, tcp_ct_queue, tcp_ct_engine.
//
// Usage:
//   i_seg carries one received segment's four-tuple per beat; o_res returns
//   exactly one result per segment (slot, status, action, conn_state) in order.
//   i_cfg_valid/i_cfg_data write the table limit (5 bits, saturated at
//   CAPACITY); o_cfg_ready is always high. Write it only while idle.
// Operation:
//   A segment sits in a two-deep queue, then the engine scans the table one
//   entry per cycle through the registered read port of the table memory.
//   A miss scans every filled entry (none on an empty table) and a hit
//   stops at the matching entry. The engine takes the next segment only
//   after the result of the current one is in the output register.
// Reset:
//   Synchronous, active low. Clears the fill count, sets the limit to 16.
// Stalls:
//   A result waits in the output register while o_res.ready is low; the
//   queue keeps accepting segments until both of its slots are taken.
module tcp_connection_tracker #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tcp_ct_seg_if.sink                    i_seg,
    tcp_ct_res_if.source                  o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcp_ct_pkg::LIMIT_W-1:0] i_cfg_data
);
    import tcp_ct_pkg::*;

    logic [LIMIT_W-1:0] r_table_limit;
    t_q_head            head;
    logic               pop;

    // Limit register; writes always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_limit <= LIMIT_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_table_limit <= i_cfg_data;
        end
    end

    tcp_ct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (i_seg),
        .o_head  (head),
        .i_pop   (pop)
    );

    tcp_ct_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .i_limit (r_table_limit),
        .o_res   (o_res)
    );

endmodule

@@ sim/tb_tcp_connection_tracker.sv @@
// Testbench for tcp_connection_tracker: drives segment four-tuples and table limits,
// predicts each lookup result and checks every result beat in order.
// Depends on tcp_ct_pkg, tcp_ct_ifs and the tracker RTL.
`timescale 1ns / 1ps

module tb_tcp_connection_tracker;
    import tcp_ct_pkg::*;

    localparam int CAPACITY        = 16;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int RANDOM_ITEMS    = 1880;
    localparam int N_PHASES        = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = CAPACITY + 8;
    // Limits per random phase: lowered below the fill count, zero, growing,
    // saturating above capacity, lowered again, then raised to saturate once more
    localparam logic [LIMIT_W-1:0] PHASE_LIMITS [N_PHASES] =
        '{5'd2, 5'd0, 5'd6, 5'd9, 5'd31, 5'd4, 5'd1, 5'd16, 5'd20, 5'd31};

    typedef struct {
        logic [3:0] slot;
        logic [1:0] status;
        logic [1:0] action;
        logic [1:0] conn_state;
    } t_lookup;

    // Connection table mirror plus the queue of lookups still owed by the block
    class conn_table_check;
        logic [LIMIT_W-1:0] table_limit;
        int                 filled;
        t_tuple             tuples [CAPACITY];
        logic [1:0]         states [CAPACITY];
        t_lookup            pending_lookups [$];
        int                 errors;
        int                 n_created;
        int                 n_matched;
        int                 n_full;

        function new();
            table_limit = 5'd16;
            filled      = 0;
            errors      = 0;
            n_created   = 0;
            n_matched   = 0;
            n_full      = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            table_limit = value;
        endfunction

        // Search, append on miss if there is room, then advance the handshake
        function t_lookup predict_lookup(t_tuple t);
            t_lookup    r;
            int         idx;
            int         lim;
            bit         hit;
            logic [1:0] st;
            hit = 1'b0;
            idx = 0;
            for (int i = 0; i < filled; i++) begin
                if (!hit && tuples[i] == t) begin
                    hit = 1'b1;
                    idx = i;
                end
            end
            lim = (int'(table_limit) > CAPACITY) ? CAPACITY : int'(table_limit);
            r.action = ACT_NONE;
            if (!hit && filled >= lim) begin
                n_full++;
                r.slot       = 4'd0;
                r.status     = STATUS_FULL;
                r.conn_state = ST_CLOSED;
                return r;
            end
            if (hit) begin
                n_matched++;
                r.status = STATUS_MATCHED;
            end else begin
                n_created++;
                idx         = filled;
                tuples[idx] = t;
                states[idx] = ST_LISTEN;
                filled++;
                r.status = STATUS_CREATED;
            end
            st = states[idx];
            case (st)
                ST_LISTEN: begin
                    r.action = ACT_SYN_ACK;
                    st       = ST_SYN_RECEIVED;
                end
                ST_SYN_RECEIVED: begin
                    r.action = ACT_SEND_DATA;
                    st       = ST_ESTABLISHED;
                end
                default: ;
            endcase
            states[idx]  = st;
            r.slot       = idx[3:0];
            r.conn_state = st;
            return r;
        endfunction

        function void note_segment(t_tuple t);
            pending_lookups.push_back(predict_lookup(t));
        endfunction

        function void cmp_field(string field, logic [3:0] want, logic [3:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_lookup(t_lookup got);
            t_lookup want;
            if (pending_lookups.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: expected none, %s %0d status %0d",
                         $time, "actual slot", got.slot, got.status);
                return;
            end
            want = pending_lookups.pop_front();
            cmp_field("slot", want.slot, got.slot);
            cmp_field("status", want.status, got.status);
            cmp_field("action", want.action, got.action);
            cmp_field("conn_state", want.conn_state, got.conn_state);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [LIMIT_W-1:0] i_cfg_data;

    tcp_ct_seg_if seg_ch ();
    tcp_ct_res_if res_ch ();

    conn_table_check model = new();

    bit no_idle   = 1'b0;
    bit hold_rx   = 1'b0;
    int rx_stall  = 0;
    int cycle_count = 0;

    tcp_connection_tracker #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg       (seg_ch),
        .o_res       (res_ch),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Drive result ready: hold off for the pressure window, else stall per beat
    always @(negedge i_clk) begin
        if (hold_rx) begin
            res_ch.ready = 1'b0;
        end else if (rx_stall > 0) begin
            res_ch.ready = 1'b0;
            rx_stall--;
        end else begin
            res_ch.ready = 1'b1;
        end
    end

    // Check result beats and watch the cycle budget
    always @(posedge i_clk) begin : res_monitor
        t_lookup got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, model.pending_lookups.size());
            $display("tb_tcp_connection_tracker: FAIL");
            $finish;
        end else if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.slot       = res_ch.slot;
            got.status     = res_ch.status;
            got.action     = res_ch.action;
            got.conn_state = res_ch.conn_state;
            model.check_lookup(got);
            rx_stall = no_idle ? 0 : $urandom_range(0, 16);
        end
    end

    // Offer one segment beat after a random gap and hold it until accepted
    task automatic send_segment(input t_tuple t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            seg_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        seg_ch.valid       = 1'b1;
        seg_ch.source_ip   = t.src_addr;
        seg_ch.source_port = t.src_port;
        seg_ch.dest_ip     = t.dst_addr;
        seg_ch.dest_port   = t.dst_port;
        do @(posedge i_clk); while (!seg_ch.ready);
        model.note_segment(t);
        @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        model.set_limit(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drain every owed result so the block is idle before a limit write
    task automatic wait_idle();
        seg_ch.valid = 1'b0;
        while (model.pending_lookups.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Field value biased toward all zeros and all ones
    function automatic logic [31:0] skewed_word();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Half repeat known connections, some one-bit near misses, rest new tuples
    function automatic t_tuple pick_tuple();
        t_tuple t;
        int     r;
        r = $urandom_range(0, 99);
        if (model.filled == 0 || r >= 65) begin
            t.src_addr = skewed_word();
            t.src_port = 16'(skewed_word());
            t.dst_addr = skewed_word();
            t.dst_port = 16'(skewed_word());
            return t;
        end
        t = model.tuples[$urandom_range(0, model.filled - 1)];
        if (r >= 50) t = t ^ (96'd1 << $urandom_range(0, TUPLE_W - 1));
        return t;
    endfunction

    initial begin
        t_tuple zero_t;
        t_tuple ones_t;
        t_tuple probe_t;
        i_rst_n            = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_data         = '0;
        seg_ch.valid       = 1'b0;
        seg_ch.source_ip   = '0;
        seg_ch.source_port = '0;
        seg_ch.dest_ip     = '0;
        seg_ch.dest_port   = '0;
        res_ch.ready       = 1'b0;
        zero_t             = '0;
        ones_t             = '1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Single entry: walk listen to established, then hit the full table
        write_limit(5'd1);
        send_segment(zero_t);
        send_segment(zero_t);
        send_segment(zero_t);
        send_segment(ones_t);

        // Zero limit: drop every new tuple, existing entry still found
        wait_idle();
        write_limit(5'd0);
        send_segment(ones_t);
        send_segment(zero_t);

        // Limit at capacity: create the all-ones entry and entries that differ from the first in one bit
        wait_idle();
        write_limit(5'd16);
        send_segment(ones_t);
        probe_t = zero_t;
        probe_t.src_addr[31] = 1'b1;
        send_segment(probe_t);
        probe_t = zero_t;
        probe_t.dst_port[0] = 1'b1;
        send_segment(probe_t);
        send_segment(ones_t);
        send_segment(ones_t);

        // Random phases, one table limit each
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            write_limit(PHASE_LIMITS[p]);
            no_idle = (p % 3 == 2);
            if (p == 5) begin
                fork
                    begin
                        @(posedge i_clk);
                        hold_rx = 1'b1;
                        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                        hold_rx = 1'b0;
                    end
                join_none
            end
            repeat (RANDOM_ITEMS / N_PHASES) send_segment(pick_tuple());
        end

        seg_ch.valid = 1'b0;
        while (model.pending_lookups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d segments: %0d new connections, %0d lookups of known ones, %0d drops",
                 model.n_created + model.n_matched + model.n_full,
                 model.n_created, model.n_matched, model.n_full);
        $display("Limits swept 0 to 31 with saturation and lowering; %0d-cycle result back-pressure",
                 HOLD_OFF_CYCLES);
        if (model.errors == 0) begin
            $display("tb_tcp_connection_tracker: PASS");
        end else begin
            $display("tb_tcp_connection_tracker: FAIL");
        end
        $finish;
    end

endmodule

@@ tcp_connection_tracker.f @@
+incdir+sv
sv/tcp_ct_pkg.sv
sv/tcp_ct_ifs.sv
sv/tcp_ct_queue.sv
sv/tcp_ct_engine.sv
sv/tcp_connection_tracker.sv
sim/tb_tcp_connection_tracker.sv
